// File: hw/rtl/gyro_bias_calibration_assert.svh
// Assertion macros for the gyro bias calibration block.
`ifndef GYRO_BIAS_CALIBRATION_ASSERT_SVH
`define GYRO_BIAS_CALIBRATION_ASSERT_SVH

`ifndef SYNTH
`define GBC_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("gbc assertion failed");
`define GBC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gbc assertion failed");
`else
`define GBC_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define GBC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: hw/rtl/gbc_pkg.sv
// Shared types and constants of the gyro bias calibration block.
`default_nettype none
package gbc_pkg;

    localparam int unsigned MAX_SAMPLES_DEF = 65535;
    localparam int unsigned MIN_SAMPLES_DEF = 10;
    localparam logic [15:0] TARGET_RESET    = 16'd655;

    localparam int unsigned DIV_NUM_W = 40;
    localparam int unsigned DIV_DEN_W = 16;

    localparam logic [2:0] STATUS_COLLECTING = 3'd0;
    localparam logic [2:0] STATUS_ROUND_DONE = 3'd1;
    localparam logic [2:0] STATUS_RESTARTED  = 3'd2;
    localparam logic [2:0] STATUS_FINISHED   = 3'd3;
    localparam logic [2:0] STATUS_IDLE       = 3'd4;

    localparam logic ACTION_START  = 1'b0;
    localparam logic ACTION_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_COARSE,
        PH_FINE
    } t_phase;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_O1,
        ST_O2,
        ST_O3,
        ST_O4,
        ST_SP1,
        ST_SP2,
        ST_SP3,
        ST_SP4,
        ST_OCMP,
        ST_U1,
        ST_U2,
        ST_U3,
        ST_U4,
        ST_U5,
        ST_T1,
        ST_T2,
        ST_T3,
        ST_TEST,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] dividend;
        logic [DIV_DEN_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quotient;
    } t_div_rsp;

endpackage
`default_nettype wire

// File: hw/rtl/gbc_if.sv
// Valid/ready channel interfaces for samples and results.
`default_nettype none
interface gbc_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic signed [15:0] gyro_sample;

    modport source (output valid, output action, output gyro_sample, input ready);
    modport sink   (input valid, input action, input gyro_sample, output ready);
endinterface

interface gbc_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic               offset_write;
    logic signed [15:0] device_offset;
    logic signed [23:0] residual_offset_q8;

    modport source (output valid, output status, output offset_write,
                    output device_offset, output residual_offset_q8, input ready);
    modport sink   (input valid, input status, input offset_write,
                    input device_offset, input residual_offset_q8, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/gbc_mul.sv
// Shared 32x32 unsigned multiplier with registered product.
`default_nettype none
module gbc_mul (
    input  wire logic        i_clk,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output logic      [63:0] o_p
);
    logic [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= 64'(i_a) * 64'(i_b);
    end

    assign o_p = r_p;
endmodule
`default_nettype wire

// File: hw/rtl/gbc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module gbc_div (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire gbc_pkg::t_div_req i_req,
    output gbc_pkg::t_div_rsp      o_rsp
);
    localparam int unsigned NW = gbc_pkg::DIV_NUM_W;
    localparam int unsigned DW = gbc_pkg::DIV_DEN_W;
    localparam int unsigned CW = $clog2(NW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_rem;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_den;
    logic [DW:0]   w_sh;
    logic          w_ge;

    assign w_sh = {r_rem, r_quo[NW-1]};
    assign w_ge = w_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CW'(NW - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_cnt <= '0;
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CW'(1);
            r_rem <= w_ge ? DW'(w_sh - {1'b0, r_den}) : w_sh[DW-1:0];
            r_quo <= {r_quo[NW-2:0], w_ge};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;
endmodule
`default_nettype wire

// File: hw/rtl/gyro_bias_calibration.sv
// Gyro bias calibration block: integer mean and variance estimator.
// Usage:
//   i_in carries one transaction per command: action 0 starts a calibration,
//   action 1 delivers a signed z gyro sample. o_out returns exactly one
//   result transaction per input transaction (status, offset write flag,
//   device offset, fine residual in Q8). i_cfg_we/i_cfg_wdata set the fine
//   target variance; write it only while the block is idle.
// Processing: a start command or a sample while idle goes straight to the
//   output state. A sample runs the update, spread and test states in the
//   coarse phase, after the outlier states once the outlier test runs (these
//   lead to output when the sample restarts the calibration), plus the
//   threshold states in the fine phase; at the end of a round or of the fine
//   phase the 40-bit quotient comes one bit per cycle out of the divider.
//   Each product goes through the one shared 32x32 multiplier, one product
//   per cycle. i_in.ready is high only while no transaction is in work; the
//   result becomes valid at the same edge at which i_in.ready returns.
// Reset: statistics and coarse offset clear, phase idle, target 655.
// Stall: the result waits in the output register; the next transaction is
//   accepted meanwhile, and its result holds until the register frees up.
`default_nettype none
module gyro_bias_calibration #(
    parameter int unsigned MAX_SAMPLES = gbc_pkg::MAX_SAMPLES_DEF,
    parameter int unsigned MIN_SAMPLES = gbc_pkg::MIN_SAMPLES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    gbc_in_if.sink           i_in,
    gbc_out_if.source        o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata
);
    gbc_pkg::t_state r_state, n_state;
    gbc_pkg::t_phase r_phase;

    logic        [15:0] r_n;
    logic signed [31:0] r_s;
    logic        [47:0] r_q;
    logic signed [15:0] r_off;
    logic        [15:0] r_tgt;
    logic signed [15:0] r_x;
    logic        [31:0] r_m;
    logic        [63:0] r_mm;
    logic        [63:0] r_t0;
    logic        [47:0] r_n3;
    logic        [63:0] r_thr;
    logic               r_after;
    logic               r_neg;

    logic        [2:0]  r_ps;
    logic               r_pw;
    logic signed [15:0] r_pd;
    logic signed [23:0] r_pr;

    logic               r_ov;
    logic        [2:0]  r_os;
    logic               r_ow;
    logic signed [15:0] r_od;
    logic signed [23:0] r_or;

    logic [31:0] w_a, w_b;
    logic [63:0] w_p;
    gbc_pkg::t_div_req w_dreq;
    gbc_pkg::t_div_rsp w_drsp;

    logic        [15:0] w_ax;
    logic        [31:0] w_as;
    logic signed [33:0] w_nx;
    logic signed [33:0] w_dv;
    logic        [63:0] w_d;
    logic               w_outlier;
    logic               w_min_ok;
    logic               w_done;
    logic signed [40:0] w_qs;
    logic signed [41:0] w_acc;
    logic signed [15:0] w_off_new;
    logic               w_accept;
    logic               w_slot;

    gbc_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_a),
        .i_b   (w_b),
        .o_p   (w_p)
    );

    gbc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .o_rsp   (w_drsp)
    );

    assign w_accept = i_in.valid && i_in.ready;
    assign w_slot   = !r_ov || o_out.ready;
    assign w_ax     = r_x[15] ? 16'(-r_x) : 16'(r_x);
    assign w_as     = r_s[31] ? 32'(-r_s) : 32'(r_s);
    assign w_nx     = $signed({2'b00, w_p[31:0]});
    assign w_dv     = $signed({{2{r_s[31]}}, r_s}) - (r_x[15] ? -w_nx : w_nx);
    assign w_d      = (r_t0 > w_p) ? (r_t0 - w_p) : 64'd0;
    assign w_outlier = {2'b00, r_mm} > {r_t0, 2'b00};
    assign w_min_ok = r_n >= 16'(MIN_SAMPLES);
    assign w_done   = (w_min_ok && ((r_phase == gbc_pkg::PH_COARSE)
                        ? ({r_t0, 2'b00} <= {18'd0, r_n3})
                        : (r_t0 <= r_thr)))
                      || (r_n >= 16'(MAX_SAMPLES));
    assign w_qs     = r_neg ? -$signed({1'b0, w_drsp.quotient})
                            : $signed({1'b0, w_drsp.quotient});
    assign w_acc    = $signed({{26{r_off[15]}}, r_off}) + $signed({w_qs[40], w_qs});
    assign w_off_new = (w_acc > 42'sd32767)  ? 16'sd32767 :
                       (w_acc < -42'sd32767) ? -16'sd32767 : 16'(w_acc);

    always_comb begin
        n_state = r_state;
        case (r_state)
            gbc_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (i_in.action == gbc_pkg::ACTION_START || r_phase == gbc_pkg::PH_IDLE) begin
                        n_state = gbc_pkg::ST_OUT;
                    end else if (r_phase == gbc_pkg::PH_COARSE && r_n >= 16'(MIN_SAMPLES)) begin
                        n_state = gbc_pkg::ST_O1;
                    end else begin
                        n_state = gbc_pkg::ST_U1;
                    end
                end
            end
            gbc_pkg::ST_O1:  n_state = gbc_pkg::ST_O2;
            gbc_pkg::ST_O2:  n_state = gbc_pkg::ST_O3;
            gbc_pkg::ST_O3:  n_state = gbc_pkg::ST_O4;
            gbc_pkg::ST_O4:  n_state = gbc_pkg::ST_SP1;
            gbc_pkg::ST_SP1: n_state = gbc_pkg::ST_SP2;
            gbc_pkg::ST_SP2: n_state = gbc_pkg::ST_SP3;
            gbc_pkg::ST_SP3: n_state = gbc_pkg::ST_SP4;
            gbc_pkg::ST_SP4: begin
                if (!r_after) begin
                    n_state = gbc_pkg::ST_OCMP;
                end else if (r_phase == gbc_pkg::PH_FINE) begin
                    n_state = gbc_pkg::ST_T1;
                end else begin
                    n_state = gbc_pkg::ST_TEST;
                end
            end
            gbc_pkg::ST_OCMP: n_state = w_outlier ? gbc_pkg::ST_OUT : gbc_pkg::ST_U1;
            gbc_pkg::ST_U1:  n_state = gbc_pkg::ST_U2;
            gbc_pkg::ST_U2:  n_state = gbc_pkg::ST_U3;
            gbc_pkg::ST_U3:  n_state = gbc_pkg::ST_U4;
            gbc_pkg::ST_U4:  n_state = gbc_pkg::ST_U5;
            gbc_pkg::ST_U5:  n_state = gbc_pkg::ST_SP1;
            gbc_pkg::ST_T1:  n_state = gbc_pkg::ST_T2;
            gbc_pkg::ST_T2:  n_state = gbc_pkg::ST_T3;
            gbc_pkg::ST_T3:  n_state = gbc_pkg::ST_TEST;
            gbc_pkg::ST_TEST: n_state = w_done ? gbc_pkg::ST_DIV : gbc_pkg::ST_OUT;
            gbc_pkg::ST_DIV: n_state = w_drsp.done ? gbc_pkg::ST_OUT : gbc_pkg::ST_DIV;
            gbc_pkg::ST_OUT: n_state = w_slot ? gbc_pkg::ST_IDLE : gbc_pkg::ST_OUT;
            default:         n_state = gbc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        w_a = '0;
        w_b = '0;
        w_dreq.start    = 1'b0;
        w_dreq.dividend = (r_phase == gbc_pkg::PH_FINE) ? {w_as, 8'd0} : {8'd0, w_as};
        w_dreq.divisor  = r_n;
        case (r_state)
            gbc_pkg::ST_O1: begin
                w_a = 32'(r_n);
                w_b = 32'(w_ax);
            end
            gbc_pkg::ST_O3: begin
                w_a = r_m;
                w_b = r_m;
            end
            gbc_pkg::ST_SP1: begin
                w_a = 32'(r_n);
                w_b = 32'(r_q[23:0]);
            end
            gbc_pkg::ST_SP2: begin
                w_a = 32'(r_n);
                w_b = 32'(r_q[47:24]);
            end
            gbc_pkg::ST_SP3: begin
                w_a = w_as;
                w_b = w_as;
            end
            gbc_pkg::ST_U1: begin
                w_a = 32'(w_ax);
                w_b = 32'(w_ax);
            end
            gbc_pkg::ST_U3: begin
                w_a = 32'(r_n);
                w_b = 32'(r_n);
            end
            gbc_pkg::ST_U4: begin
                w_a = w_p[31:0];
                w_b = 32'(r_n);
            end
            gbc_pkg::ST_T1: begin
                w_a = 32'(r_n3[23:0]);
                w_b = 32'(r_tgt);
            end
            gbc_pkg::ST_T2: begin
                w_a = 32'(r_n3[47:24]);
                w_b = 32'(r_tgt);
            end
            gbc_pkg::ST_TEST: begin
                w_dreq.start = w_done;
            end
            default: begin
                w_a = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gbc_pkg::ST_IDLE;
            r_phase <= gbc_pkg::PH_IDLE;
            r_n     <= '0;
            r_s     <= '0;
            r_q     <= '0;
            r_off   <= '0;
            r_tgt   <= gbc_pkg::TARGET_RESET;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_tgt <= i_cfg_wdata;
            end
            if (r_state == gbc_pkg::ST_OUT && w_slot) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                gbc_pkg::ST_IDLE: begin
                    if (w_accept && i_in.action == gbc_pkg::ACTION_START) begin
                        r_n     <= '0;
                        r_s     <= '0;
                        r_q     <= '0;
                        r_off   <= '0;
                        r_phase <= gbc_pkg::PH_COARSE;
                    end
                end
                gbc_pkg::ST_OCMP: begin
                    if (w_outlier) begin
                        r_n   <= '0;
                        r_s   <= '0;
                        r_q   <= '0;
                        r_off <= '0;
                    end
                end
                gbc_pkg::ST_U2: begin
                    r_n <= r_n + 16'd1;
                    r_s <= r_s + 32'(r_x);
                    r_q <= r_q + 48'(w_p[31:0]);
                end
                gbc_pkg::ST_DIV: begin
                    if (w_drsp.done) begin
                        r_n <= '0;
                        r_s <= '0;
                        r_q <= '0;
                        if (r_phase == gbc_pkg::PH_COARSE) begin
                            r_off <= w_off_new;
                            if (w_drsp.quotient == '0) begin
                                r_phase <= gbc_pkg::PH_FINE;
                            end
                        end else begin
                            r_phase <= gbc_pkg::PH_IDLE;
                        end
                    end
                end
                default: begin
                    r_n <= r_n;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == gbc_pkg::ST_OUT && w_slot) begin
            r_os <= r_ps;
            r_ow <= r_pw;
            r_od <= r_pd;
            r_or <= r_pr;
        end
        case (r_state)
            gbc_pkg::ST_IDLE: begin
                r_x <= i_in.gyro_sample;
                r_pr <= '0;
                if (i_in.action == gbc_pkg::ACTION_START) begin
                    r_ps <= gbc_pkg::STATUS_COLLECTING;
                    r_pw <= 1'b1;
                    r_pd <= '0;
                end else begin
                    r_ps <= gbc_pkg::STATUS_IDLE;
                    r_pw <= 1'b0;
                    r_pd <= -r_off;
                end
            end
            gbc_pkg::ST_O2:  r_m <= w_dv[33] ? 32'(-w_dv) : 32'(w_dv);
            gbc_pkg::ST_O4: begin
                r_mm    <= w_p;
                r_after <= 1'b0;
            end
            gbc_pkg::ST_SP2: r_t0 <= w_p;
            gbc_pkg::ST_SP3: r_t0 <= r_t0 + {w_p[39:0], 24'd0};
            gbc_pkg::ST_SP4: r_t0 <= w_d;
            gbc_pkg::ST_OCMP: begin
                r_ps <= gbc_pkg::STATUS_RESTARTED;
                r_pw <= 1'b1;
                r_pd <= '0;
                r_pr <= '0;
            end
            gbc_pkg::ST_U5: begin
                r_n3    <= w_p[47:0];
                r_after <= 1'b1;
            end
            gbc_pkg::ST_T2: r_thr <= w_p;
            gbc_pkg::ST_T3: r_thr <= (r_thr + {w_p[39:0], 24'd0}) >> 16;
            gbc_pkg::ST_TEST: begin
                r_neg <= r_s[31];
                r_ps  <= gbc_pkg::STATUS_COLLECTING;
                r_pw  <= 1'b0;
                r_pd  <= -r_off;
                r_pr  <= '0;
            end
            gbc_pkg::ST_DIV: begin
                if (r_phase == gbc_pkg::PH_COARSE) begin
                    r_ps <= gbc_pkg::STATUS_ROUND_DONE;
                    r_pw <= 1'b1;
                    r_pd <= -w_off_new;
                    r_pr <= '0;
                end else begin
                    r_ps <= gbc_pkg::STATUS_FINISHED;
                    r_pw <= 1'b0;
                    r_pd <= -r_off;
                    r_pr <= w_qs[23:0];
                end
            end
            default: begin
                r_x <= r_x;
            end
        endcase
    end

    assign i_in.ready               = (r_state == gbc_pkg::ST_IDLE);
    assign o_out.valid              = r_ov;
    assign o_out.status             = r_os;
    assign o_out.offset_write       = r_ow;
    assign o_out.device_offset      = r_od;
    assign o_out.residual_offset_q8 = r_or;

`include "gyro_bias_calibration_assert.svh"

    `GBC_ASSERT_ALWAYS(a_count_cap, i_clk, i_rst_n, r_n <= 16'(MAX_SAMPLES))
    `GBC_ASSERT_ALWAYS(a_offset_range, i_clk, i_rst_n, r_off != -16'sd32768)
    `GBC_ASSERT_IMPLY(a_write_status, i_clk, i_rst_n, o_out.valid && o_out.offset_write, o_out.status == gbc_pkg::STATUS_COLLECTING || o_out.status == gbc_pkg::STATUS_ROUND_DONE || o_out.status == gbc_pkg::STATUS_RESTARTED)
    `GBC_ASSERT_IMPLY(a_residual_zero, i_clk, i_rst_n, o_out.valid && o_out.status != gbc_pkg::STATUS_FINISHED, o_out.residual_offset_q8 == 24'sd0)

endmodule
`default_nettype wire
